[hdl/cah_pkg.sv]
`default_nettype none

package cah_pkg;

	localparam int DEF_CHANNELS = 16;

	localparam logic [1:0] LVL_OK   = 2'd0;
	localparam logic [1:0] LVL_WARN = 2'd1;
	localparam logic [1:0] LVL_CRIT = 2'd2;

	localparam logic [2:0] SEL_CRIT_HI = 3'd0;
	localparam logic [2:0] SEL_CRIT_LO = 3'd1;
	localparam logic [2:0] SEL_WARN_HI = 3'd2;
	localparam logic [2:0] SEL_WARN_LO = 3'd3;
	localparam logic [2:0] SEL_HYST    = 3'd4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [3:0]         channel;
		logic signed [15:0] sample_value;
		logic               sample_valid;
		logic [2:0]         limit_select;
		logic               limit_enabled;
	} in_item_t;

	typedef struct packed {
		logic [1:0] level;
		logic [1:0] worst_level;
	} out_item_t;

	typedef struct packed {
		logic               en;
		logic signed [15:0] val;
	} limit_t;

	typedef struct packed {
		logic [1:0]         level;
		limit_t             crit_hi;
		limit_t             crit_lo;
		limit_t             warn_hi;
		limit_t             warn_lo;
		logic signed [15:0] hyst;
	} chan_rec_t;

	localparam chan_rec_t REC_RESET = '0;

	function automatic logic past_high(input limit_t l, input logic signed [15:0] v);
		return l.en && (v >= l.val);
	endfunction

	function automatic logic past_low(input limit_t l, input logic signed [15:0] v);
		return l.en && (v <= l.val);
	endfunction

	// limit minus hysteresis formed at 17 bits, never overflows
	function automatic logic clear_high(input limit_t l, input logic signed [15:0] v,
			input logic signed [15:0] h);
		logic signed [16:0] v17;
		logic signed [16:0] t17;
		v17 = {v[15], v};
		t17 = $signed({l.val[15], l.val}) - $signed({h[15], h});
		return !l.en || (v17 < t17);
	endfunction

	function automatic logic clear_low(input limit_t l, input logic signed [15:0] v,
			input logic signed [15:0] h);
		logic signed [16:0] v17;
		logic signed [16:0] t17;
		v17 = {v[15], v};
		t17 = $signed({l.val[15], l.val}) + $signed({h[15], h});
		return !l.en || (v17 > t17);
	endfunction

endpackage

`default_nettype wire

[hdl/cah_store.sv]
`default_nettype none

module cah_store #(
	parameter int CHANNELS = cah_pkg::DEF_CHANNELS,
	parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     rd_en,
	input  wire  [IDX_W-1:0]        rd_idx,
	output cah_pkg::chan_rec_t      rd_rec,
	input  wire                     wr_en,
	input  wire  [IDX_W-1:0]        wr_idx,
	input  cah_pkg::chan_rec_t      wr_data
);
	import cah_pkg::*;

	chan_rec_t           mem_q [CHANNELS];
	chan_rec_t           rd_data_q;
	chan_rec_t           byp_q;
	logic [CHANNELS-1:0] vld_q;
	logic                rd_vld_q;
	logic                fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
			byp_q         <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
				// the write on this same edge is not yet in the read data
				fwd_q    <= wr_en && (wr_idx == rd_idx);
			end
		end
	end

	assign rd_rec = fwd_q ? byp_q : (rd_vld_q ? rd_data_q : REC_RESET);

endmodule

`default_nettype wire

[hdl/cah_classify.sv]
`default_nettype none

module cah_classify (
	input  cah_pkg::in_item_t  item,
	input  cah_pkg::chan_rec_t rec,
	output cah_pkg::chan_rec_t new_rec
);
	import cah_pkg::*;

	logic signed [15:0] v;
	logic [1:0]         raw;
	logic [1:0]         cur;
	logic               warn_clear;
	logic               crit_clear;

	always_comb begin
		v          = item.sample_value;
		cur        = rec.level;
		warn_clear = clear_high(rec.warn_hi, v, rec.hyst) && clear_low(rec.warn_lo, v, rec.hyst);
		crit_clear = clear_high(rec.crit_hi, v, rec.hyst) && clear_low(rec.crit_lo, v, rec.hyst);

		if (past_high(rec.crit_hi, v) || past_low(rec.crit_lo, v)) begin
			raw = LVL_CRIT;
		end else if (past_high(rec.warn_hi, v) || past_low(rec.warn_lo, v)) begin
			raw = LVL_WARN;
		end else begin
			raw = LVL_OK;
		end

		new_rec = rec;
		if (item.cmd == CMD_LOAD) begin
			case (item.limit_select)
				SEL_CRIT_HI: begin
					new_rec.crit_hi.en  = item.limit_enabled;
					new_rec.crit_hi.val = v;
				end
				SEL_CRIT_LO: begin
					new_rec.crit_lo.en  = item.limit_enabled;
					new_rec.crit_lo.val = v;
				end
				SEL_WARN_HI: begin
					new_rec.warn_hi.en  = item.limit_enabled;
					new_rec.warn_hi.val = v;
				end
				SEL_WARN_LO: begin
					new_rec.warn_lo.en  = item.limit_enabled;
					new_rec.warn_lo.val = v;
				end
				SEL_HYST: begin
					new_rec.hyst = v;
				end
				default: begin
				end
			endcase
		end else if (item.sample_valid) begin
			if (raw > cur) begin
				new_rec.level = raw;
			end else if (raw < cur) begin
				if (cur == LVL_CRIT) begin
					// drop from critical lands on warning unless warning is clear too
					if (crit_clear) begin
						new_rec.level = (raw == LVL_OK && warn_clear) ? LVL_OK : LVL_WARN;
					end
				end else if (cur == LVL_WARN) begin
					if (warn_clear) begin
						new_rec.level = LVL_OK;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[hdl/cah_worst.sv]
`default_nettype none

module cah_worst #(
	parameter int CHANNELS = cah_pkg::DEF_CHANNELS
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        upd,
	input  wire  [1:0] old_level,
	input  wire  [1:0] new_level,
	output logic [1:0] worst
);
	import cah_pkg::*;

	localparam int CW = $clog2(CHANNELS + 1);

	logic [CW-1:0] crit_cnt_q;
	logic [CW-1:0] warn_cnt_q;
	logic [CW-1:0] crit_cnt_d;
	logic [CW-1:0] warn_cnt_d;

	// per-level channel counts; move one channel between counts per write
	always_comb begin
		crit_cnt_d = crit_cnt_q;
		warn_cnt_d = warn_cnt_q;
		if (upd) begin
			crit_cnt_d = crit_cnt_q + CW'(new_level == LVL_CRIT) - CW'(old_level == LVL_CRIT);
			warn_cnt_d = warn_cnt_q + CW'(new_level == LVL_WARN) - CW'(old_level == LVL_WARN);
		end
		if (crit_cnt_d != '0) begin
			worst = LVL_CRIT;
		end else if (warn_cnt_d != '0) begin
			worst = LVL_WARN;
		end else begin
			worst = LVL_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_cnt_q <= '0;
			warn_cnt_q <= '0;
		end else begin
			crit_cnt_q <= crit_cnt_d;
			warn_cnt_q <= warn_cnt_d;
		end
	end

endmodule

`default_nettype wire

[hdl/channel_alarm_hysteresis.sv]
// Per-channel alarm classifier with hysteresis.
// Input channel (item, item_valid, item_stall): each beat either loads one
// limit of a channel (cmd = 1) or classifies a sample (cmd = 0) as OK, WARN
// or CRIT. Output channel (result, result_valid, result_stall): exactly one
// beat per input beat, in order, with the channel's level and the worst
// level over all channels after that item.
// An accepted item is registered in the update stage, then in the result
// register. Throughput: one item per cycle unless result_stall holds a
// pending result. Each channel's limits and level live in one record
// memory; an item reads its record on acceptance, and the update stage
// writes it back when the item advances. A write that lands on the same
// edge as the read of the same channel is forwarded, so back-to-back items
// on one channel are fine. Reset: all limits disabled, all levels OK; the
// block takes items as soon as reset is released.
// When result_stall is high with a result pending, the next item holds in
// the update stage and item_stall rises in the same cycle.
`default_nettype none

module channel_alarm_hysteresis #(
	parameter int CHANNELS = cah_pkg::DEF_CHANNELS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  cah_pkg::in_item_t   item,
	input  wire                 item_valid,
	output logic                item_stall,
	output cah_pkg::out_item_t  result,
	output logic                result_valid,
	input  wire                 result_stall
);
	import cah_pkg::*;

	localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_EXT = (IDX_W > 4) ? IDX_W : 4;

	logic              accept;
	logic              adv_s1;
	logic              valid_s1;
	in_item_t          item_s1;
	logic              in_range_s1;
	logic [CH_EXT-1:0] ch_ext;
	logic [IDX_W-1:0]  rd_idx;
	logic [IDX_W-1:0]  idx_s1;
	logic              in_range;
	chan_rec_t         rec;
	chan_rec_t         new_rec;
	logic              wr_en;
	logic [1:0]        worst;
	out_item_t         result_q;
	logic              result_valid_q;

	assign ch_ext   = CH_EXT'(item.channel);
	assign rd_idx   = ch_ext[IDX_W-1:0];
	assign in_range = int'(item.channel) < CHANNELS;

	assign accept     = item_valid && !item_stall;
	assign adv_s1     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign wr_en      = adv_s1 && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !adv_s1);
			if (adv_s1) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			idx_s1      <= rd_idx;
			in_range_s1 <= in_range;
		end
		if (adv_s1) begin
			result_q.level       <= in_range_s1 ? new_rec.level : LVL_OK;
			result_q.worst_level <= worst;
		end
	end

	cah_store #(
		.CHANNELS (CHANNELS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_idx  (rd_idx),
		.rd_rec  (rec),
		.wr_en   (wr_en),
		.wr_idx  (idx_s1),
		.wr_data (new_rec)
	);

	cah_classify u_classify (
		.item    (item_s1),
		.rec     (rec),
		.new_rec (new_rec)
	);

	cah_worst #(
		.CHANNELS (CHANNELS)
	) u_worst (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (wr_en),
		.old_level (rec.level),
		.new_level (new_rec.level),
		.worst     (worst)
	);

	assign result       = result_q;
	assign result_valid = result_valid_q;

	a_worst_covers_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.worst_level >= result.level)
		else $error("worst level below channel level");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty update stage");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> result_valid)
		else $error("advanced item did not reach the output register");

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import cah_pkg::*;

	localparam int NCH = DEF_CHANNELS;
	localparam int RANDOM_ITEMS = 1050;
	localparam int PHASE_ITEMS = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	// selector codes that address no limit
	localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
	localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	class alarm_scoreboard;
		logic [1:0]         lvl [NCH];
		limit_t             crit_hi [NCH];
		limit_t             crit_lo [NCH];
		limit_t             warn_hi [NCH];
		limit_t             warn_lo [NCH];
		logic signed [15:0] hyst [NCH];
		out_item_t          due_levels [$];
		int                 errors;

		function new();
			for (int i = 0; i < NCH; i++) begin
				lvl[i] = LVL_OK;
				crit_hi[i] = '0;
				crit_lo[i] = '0;
				warn_hi[i] = '0;
				warn_lo[i] = '0;
				hyst[i] = '0;
			end
			errors = 0;
		endfunction

		function bit at_or_above(limit_t l, logic signed [15:0] v);
			logic signed [16:0] a;
			logic signed [16:0] b;
			a = {v[15], v};
			b = {l.val[15], l.val};
			return l.en && (a >= b);
		endfunction

		function bit at_or_below(limit_t l, logic signed [15:0] v);
			logic signed [16:0] a;
			logic signed [16:0] b;
			a = {v[15], v};
			b = {l.val[15], l.val};
			return l.en && (a <= b);
		endfunction

		// release point is limit -/+ hysteresis, exact at 17 bits
		function bit released_high(limit_t l, logic signed [15:0] v, logic signed [15:0] h);
			logic signed [16:0] a;
			logic signed [16:0] t;
			a = {v[15], v};
			t = {l.val[15], l.val} - {h[15], h};
			return !l.en || (a < t);
		endfunction

		function bit released_low(limit_t l, logic signed [15:0] v, logic signed [15:0] h);
			logic signed [16:0] a;
			logic signed [16:0] t;
			a = {v[15], v};
			t = {l.val[15], l.val} + {h[15], h};
			return !l.en || (a > t);
		endfunction

		function void note_item(in_item_t it);
			logic [1:0]         raw;
			logic [1:0]         cur;
			logic signed [15:0] v;
			logic signed [15:0] h;
			bit                 warn_free;
			limit_t             l;
			out_item_t          exp;
			int                 c;
			c = int'(it.channel);
			v = it.sample_value;
			exp = '0;
			if (c < NCH) begin
				if (it.cmd == CMD_LOAD) begin
					l.en = it.limit_enabled;
					l.val = it.sample_value;
					case (it.limit_select)
						SEL_CRIT_HI: crit_hi[c] = l;
						SEL_CRIT_LO: crit_lo[c] = l;
						SEL_WARN_HI: warn_hi[c] = l;
						SEL_WARN_LO: warn_lo[c] = l;
						SEL_HYST:    hyst[c] = it.sample_value;
						default: ;
					endcase
				end else if (it.sample_valid) begin
					h = hyst[c];
					cur = lvl[c];
					if (at_or_above(crit_hi[c], v) || at_or_below(crit_lo[c], v))
						raw = LVL_CRIT;
					else if (at_or_above(warn_hi[c], v) || at_or_below(warn_lo[c], v))
						raw = LVL_WARN;
					else
						raw = LVL_OK;
					warn_free = released_high(warn_hi[c], v, h) && released_low(warn_lo[c], v, h);
					if (raw > cur) begin
						cur = raw;
					end else if (raw < cur) begin
						if (cur == LVL_CRIT) begin
							if (released_high(crit_hi[c], v, h) && released_low(crit_lo[c], v, h))
								cur = (raw == LVL_OK && warn_free) ? LVL_OK : LVL_WARN;
						end else if (cur == LVL_WARN) begin
							if (warn_free)
								cur = LVL_OK;
						end
					end
					lvl[c] = cur;
				end
				exp.level = lvl[c];
			end
			exp.worst_level = LVL_OK;
			for (int i = 0; i < NCH; i++)
				if (lvl[i] > exp.worst_level)
					exp.worst_level = lvl[i];
			due_levels.push_back(exp);
		endfunction

		function void check_result(out_item_t r);
			out_item_t exp;
			if (due_levels.size() == 0) begin
				$error("result beat with no pending item: level %0d, worst_level %0d",
					r.level, r.worst_level);
				errors++;
				return;
			end
			exp = due_levels.pop_front();
			if (r.level !== exp.level) begin
				$error("level: expected %0d, actual %0d", exp.level, r.level);
				errors++;
			end
			if (r.worst_level !== exp.worst_level) begin
				$error("worst_level: expected %0d, actual %0d", exp.worst_level, r.worst_level);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_levels.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	in_item_t   item;
	logic       item_valid;
	logic       item_stall;
	out_item_t  result;
	logic       result_valid;
	logic       result_stall;

	alarm_scoreboard sb;
	idle_mode_t      idle_mode;
	int              sent_cnt;
	int              quiet_cycles;

	int sc_base [NCH];
	int sc_w1 [NCH];
	int sc_w2 [NCH];
	int sc_hy [NCH];

	channel_alarm_hysteresis dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic signed [15:0] sat16(int x);
		if (x > 32767)
			return 16'sh7fff;
		if (x < -32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 48;
			IDLE_BOTH:   return $urandom_range(0, 99) < 18;
			default:     return 1'b0;
		endcase
	endfunction

	// hold the beat until accepted, then note it for prediction
	task automatic send_item(in_item_t it);
		while (sender_gap()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_item(it);
		sent_cnt++;
		if (sent_cnt % PHASE_ITEMS == 0)
			idle_mode = idle_mode_t'((int'(idle_mode) + 1) % 4);
	endtask

	task automatic send_load(int ch, logic [2:0] sel, int val, bit en);
		in_item_t it;
		it = '0;
		it.cmd = CMD_LOAD;
		it.channel = ch[3:0];
		it.sample_value = sat16(val);
		it.sample_valid = 1'($urandom_range(0, 1));
		it.limit_select = sel;
		it.limit_enabled = en;
		send_item(it);
	endtask

	task automatic send_sample(int ch, int val, bit vld);
		in_item_t it;
		it = '0;
		it.cmd = CMD_SAMPLE;
		it.channel = ch[3:0];
		it.sample_value = sat16(val);
		it.sample_valid = vld;
		it.limit_select = 3'($urandom_range(0, 7));
		it.limit_enabled = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic send_noise();
		in_item_t it;
		it.cmd = 1'($urandom_range(0, 1));
		it.channel = 4'($urandom_range(0, 15));
		it.sample_value = 16'($urandom_range(0, 65535));
		it.sample_valid = 1'($urandom_range(0, 1));
		it.limit_select = 3'($urandom_range(0, 7));
		it.limit_enabled = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	// load an ordered limit set on one channel, then walk samples around it
	task automatic run_scenario();
		int ch;
		int n;
		int k;
		int thr;
		int off;
		int v;
		ch = $urandom_range(0, NCH - 1);
		if ($urandom_range(0, 3) != 0) begin
			sc_base[ch] = int'($urandom_range(0, 40000)) - 20000;
			sc_w1[ch] = $urandom_range(20, 2000);
			sc_w2[ch] = sc_w1[ch] + int'($urandom_range(20, 2000));
			k = $urandom_range(0, 9);
			if (k < 8)
				sc_hy[ch] = $urandom_range(0, 400);
			else if (k == 8)
				sc_hy[ch] = -int'($urandom_range(0, 200));
			else
				sc_hy[ch] = int'($urandom_range(0, 65535)) - 32768;
			send_load(ch, SEL_CRIT_HI, sc_base[ch] + sc_w2[ch], $urandom_range(0, 99) < 85);
			send_load(ch, SEL_CRIT_LO, sc_base[ch] - sc_w2[ch], $urandom_range(0, 99) < 85);
			send_load(ch, SEL_WARN_HI, sc_base[ch] + sc_w1[ch], $urandom_range(0, 99) < 85);
			send_load(ch, SEL_WARN_LO, sc_base[ch] - sc_w1[ch], $urandom_range(0, 99) < 85);
			send_load(ch, SEL_HYST, sc_hy[ch], 1'($urandom_range(0, 1)));
		end
		n = $urandom_range(3, 12);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 4) begin
				v = sc_base[ch] + int'($urandom_range(0, 2 * (sc_w2[ch] + 600)))
					- (sc_w2[ch] + 600);
			end else begin
				case ($urandom_range(0, 3))
					0: thr = sc_base[ch] + sc_w2[ch];
					1: thr = sc_base[ch] - sc_w2[ch];
					2: thr = sc_base[ch] + sc_w1[ch];
					default: thr = sc_base[ch] - sc_w1[ch];
				endcase
				case ($urandom_range(0, 6))
					0: off = 0;
					1: off = -sc_hy[ch];
					2: off = sc_hy[ch];
					3: off = -sc_hy[ch] - 1;
					4: off = sc_hy[ch] + 1;
					5: off = -1;
					default: off = 1;
				endcase
				v = thr + off;
			end
			send_sample(ch, v, $urandom_range(0, 9) != 0);
		end
	endtask

	// receiver: check accepted beats, then pick the next stall
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				sb.check_result(result);
			case (idle_mode)
				IDLE_RECEIVER: result_stall <= $urandom_range(0, 99) < 48;
				IDLE_BOTH:     result_stall <= $urandom_range(0, 99) < 18;
				default:       result_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		sb = new();
		idle_mode = IDLE_NONE;
		sent_cnt = 0;
		clk = 1'b0;
		arst_n = 1'b0;
		item = '0;
		item_valid = 1'b0;
		for (int i = 0; i < NCH; i++) begin
			sc_base[i] = 0;
			sc_w1[i] = 500;
			sc_w2[i] = 1000;
			sc_hy[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all limits disabled out of reset
		send_sample(0, 32767, 1'b1);
		send_sample(0, -32768, 1'b1);
		send_load(0, SEL_CRIT_HI, 1000, 1'b1);
		send_load(0, SEL_CRIT_LO, -1000, 1'b1);
		send_load(0, SEL_WARN_HI, 500, 1'b1);
		send_load(0, SEL_WARN_LO, -500, 1'b1);
		// enable bit ignored on a hysteresis write
		send_load(0, SEL_HYST, 100, 1'b0);
		send_sample(0, 600, 1'b1);
		send_sample(0, 1000, 1'b1);
		send_sample(0, 950, 1'b1);
		// invalid sample holds CRIT
		send_sample(0, 0, 1'b0);
		send_sample(0, 850, 1'b1);
		send_sample(0, 450, 1'b1);
		send_sample(0, 300, 1'b1);
		send_sample(0, -32768, 1'b1);
		send_sample(0, 0, 1'b1);
		// unused selectors write nothing
		send_load(0, SEL_SPARE_FIRST, 0, 1'b0);
		send_load(0, SEL_SPARE_LAST, -1, 1'b1);
		// negative hysteresis and extreme release points on the top channel
		send_load(NCH - 1, SEL_CRIT_HI, 32767, 1'b1);
		send_load(NCH - 1, SEL_CRIT_LO, -32768, 1'b1);
		send_load(NCH - 1, SEL_HYST, -32768, 1'b1);
		send_sample(NCH - 1, 32767, 1'b1);
		send_sample(NCH - 1, 32766, 1'b1);
		send_load(NCH - 1, SEL_HYST, 32767, 1'b1);
		send_sample(NCH - 1, -32768, 1'b1);
		send_load(NCH - 1, SEL_CRIT_LO, 0, 1'b0);
		send_sample(NCH - 1, 32767, 1'b1);

		begin
			int stop_at;
			stop_at = sent_cnt + RANDOM_ITEMS;
			while (sent_cnt < stop_at) begin
				if ($urandom_range(0, 9) < 2)
					send_noise();
				else
					run_scenario();
			end
		end
		item_valid <= 1'b0;

		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
